/* rtl/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 matrix inverse: entry counts, cofactor index
// tables, determinant output format and queue depths.
// ----------------------------------------------------------------------------
package mi3_pkg;

  // default entry format, signed Q16.16
  localparam int unsigned ENTRY_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // determinant output format, signed Q32.32
  localparam int unsigned DET_WIDTH = 64;
  localparam int unsigned DET_FRAC  = 32;

  // matrix entries, column-major: index = 3 * column + row
  localparam int unsigned NUM_ENTRIES   = 9;
  localparam int unsigned NUM_DET_TERMS = 3;

  // cofactor i = m[A] * m[B] - m[C] * m[D]
  localparam int unsigned COF_A [NUM_ENTRIES] = '{4, 7, 1, 6, 0, 2, 3, 1, 0};
  localparam int unsigned COF_B [NUM_ENTRIES] = '{8, 2, 5, 5, 8, 3, 7, 6, 4};
  localparam int unsigned COF_C [NUM_ENTRIES] = '{5, 1, 2, 3, 6, 0, 6, 0, 1};
  localparam int unsigned COF_D [NUM_ENTRIES] = '{7, 8, 4, 8, 2, 5, 4, 7, 3};

  // first row entries used for the determinant expansion
  localparam int unsigned DET_COL [NUM_DET_TERMS] = '{0, 3, 6};

  // queue depths between front, back and output
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

endpackage

/* rtl/matrix_inverse_3x3.sv */
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a 3x3 fixed-point matrix as adjugate over determinant, with a
// saturated Q32.32 determinant and a singular flag.
//
//   channel   | handshake        | payload
//   ----------+------------------+---------------------------------------
//   input     | push / full      | a_r1c1_i .. a_r3c3_i, column-major
//   result    | pop / empty      | inv_r1c1_o .. inv_r3c3_o, determinant_o,
//             |                  | singular_o
//
// One item per cycle sustained while the result side keeps popping. The
// divider computes one quotient bit per stage for all nine entries side
// by side.
// Reset clears only the valid bits and queue pointers; no clearing pass.
// A stalled result side fills the output queue, then the back pipeline,
// the middle queue and the front pipeline, and only then raises full.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
  parameter int unsigned ENTRY_WIDTH = mi3_pkg::ENTRY_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic push,
  output logic full,
  input  logic signed [ENTRY_WIDTH-1:0] a_r1c1_i,
  input  logic signed [ENTRY_WIDTH-1:0] a_r2c1_i,
  input  logic signed [ENTRY_WIDTH-1:0] a_r3c1_i,
  input  logic signed [ENTRY_WIDTH-1:0] a_r1c2_i,
  input  logic signed [ENTRY_WIDTH-1:0] a_r2c2_i,
  input  logic signed [ENTRY_WIDTH-1:0] a_r3c2_i,
  input  logic signed [ENTRY_WIDTH-1:0] a_r1c3_i,
  input  logic signed [ENTRY_WIDTH-1:0] a_r2c3_i,
  input  logic signed [ENTRY_WIDTH-1:0] a_r3c3_i,

  input  logic pop,
  output logic empty,
  output logic signed [ENTRY_WIDTH-1:0] inv_r1c1_o,
  output logic signed [ENTRY_WIDTH-1:0] inv_r2c1_o,
  output logic signed [ENTRY_WIDTH-1:0] inv_r3c1_o,
  output logic signed [ENTRY_WIDTH-1:0] inv_r1c2_o,
  output logic signed [ENTRY_WIDTH-1:0] inv_r2c2_o,
  output logic signed [ENTRY_WIDTH-1:0] inv_r3c2_o,
  output logic signed [ENTRY_WIDTH-1:0] inv_r1c3_o,
  output logic signed [ENTRY_WIDTH-1:0] inv_r2c3_o,
  output logic signed [ENTRY_WIDTH-1:0] inv_r3c3_o,
  output logic signed [mi3_pkg::DET_WIDTH-1:0] determinant_o,
  output logic singular_o
);

  import mi3_pkg::*;

  localparam int unsigned W     = ENTRY_WIDTH;
  localparam int unsigned CFW   = 2 * W + 1;
  localparam int unsigned DETW  = 3 * W + 2;
  localparam int unsigned MID_W = NUM_ENTRIES * CFW + DETW;
  localparam int unsigned OUT_W = NUM_ENTRIES * W + DET_WIDTH + 1;

  logic signed [W-1:0]    m [NUM_ENTRIES];
  logic                   f_valid, f_ready;
  logic signed [CFW-1:0]  f_cof [NUM_ENTRIES];
  logic signed [DETW-1:0] f_det;
  logic [MID_W-1:0]       mid_wdata, mid_rdata;
  logic                   mid_full, mid_empty;
  logic                   b_ready;
  logic signed [CFW-1:0]  b_cof [NUM_ENTRIES];
  logic signed [DETW-1:0] b_det;
  logic                   b_valid;
  logic [W-1:0]           b_inv [NUM_ENTRIES];
  logic [DET_WIDTH-1:0]   b_detq;
  logic                   b_sing;
  logic [OUT_W-1:0]       out_wdata, out_rdata;
  logic                   out_full;

  // column-major entry order
  assign m[0] = a_r1c1_i;
  assign m[1] = a_r2c1_i;
  assign m[2] = a_r3c1_i;
  assign m[3] = a_r1c2_i;
  assign m[4] = a_r2c2_i;
  assign m[5] = a_r3c2_i;
  assign m[6] = a_r1c3_i;
  assign m[7] = a_r2c3_i;
  assign m[8] = a_r3c3_i;

  // cofactors and determinant
  mi3_front #(
    .W(W)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .m_i     (m),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .cof_o   (f_cof),
    .det_o   (f_det)
  );

  assign f_ready = !mid_full;

  // pack front results for the middle queue
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      mid_wdata[i*CFW +: CFW] = f_cof[i];
    end
    mid_wdata[NUM_ENTRIES*CFW +: DETW] = f_det;
  end

  mi3_fifo #(
    .DEPTH  (MID_DEPTH),
    .DATA_W (MID_W)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (b_ready),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  // unpack for the divider
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      b_cof[i] = mid_rdata[i*CFW +: CFW];
    end
    b_det = mid_rdata[NUM_ENTRIES*CFW +: DETW];
  end

  mi3_back #(
    .W(W),
    .F(FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!mid_empty),
    .ready_o (b_ready),
    .cof_i   (b_cof),
    .det_i   (b_det),
    .valid_o (b_valid),
    .ready_i (!out_full),
    .inv_o   (b_inv),
    .det_o   (b_detq),
    .sing_o  (b_sing)
  );

  // pack results for the output queue
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      out_wdata[i*W +: W] = b_inv[i];
    end
    out_wdata[NUM_ENTRIES*W +: DET_WIDTH] = b_detq;
    out_wdata[OUT_W-1] = b_sing;
  end

  mi3_fifo #(
    .DEPTH  (OUT_DEPTH),
    .DATA_W (OUT_W)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_valid),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .empty_o (empty)
  );

  // result ports
  assign inv_r1c1_o    = out_rdata[0*W +: W];
  assign inv_r2c1_o    = out_rdata[1*W +: W];
  assign inv_r3c1_o    = out_rdata[2*W +: W];
  assign inv_r1c2_o    = out_rdata[3*W +: W];
  assign inv_r2c2_o    = out_rdata[4*W +: W];
  assign inv_r3c2_o    = out_rdata[5*W +: W];
  assign inv_r1c3_o    = out_rdata[6*W +: W];
  assign inv_r2c3_o    = out_rdata[7*W +: W];
  assign inv_r3c3_o    = out_rdata[8*W +: W];
  assign determinant_o = out_rdata[NUM_ENTRIES*W +: DET_WIDTH];
  assign singular_o    = out_rdata[OUT_W-1];

endmodule

/* rtl/mi3_fifo.sv */
// ----------------------------------------------------------------------------
// mi3_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module mi3_fifo #(
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/mi3_front.sv */
// ----------------------------------------------------------------------------
// mi3_front
// Accepts matrices and computes the nine cofactors and the exact determinant
// in a five stage pipeline that stalls as a whole.
// ----------------------------------------------------------------------------
module mi3_front #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic signed [W-1:0] m_i [mi3_pkg::NUM_ENTRIES],
  output logic                valid_o,
  input  logic                ready_i,
  output logic signed [2*W:0]   cof_o [mi3_pkg::NUM_ENTRIES],
  output logic signed [3*W+1:0] det_o
);

  import mi3_pkg::*;

  localparam int unsigned PW   = 2 * W;
  localparam int unsigned CFW  = 2 * W + 1;
  localparam int unsigned PLW  = 2 * W + 1;
  localparam int unsigned DETW = 3 * W + 2;

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  logic signed [PW-1:0]   pa_q  [NUM_ENTRIES];
  logic signed [PW-1:0]   pb_q  [NUM_ENTRIES];
  logic signed [W-1:0]    mk1_q [NUM_DET_TERMS];
  logic signed [W-1:0]    mk2_q [NUM_DET_TERMS];
  logic signed [CFW-1:0]  cof2_q [NUM_ENTRIES];
  logic signed [CFW-1:0]  cof3_q [NUM_ENTRIES];
  logic signed [CFW-1:0]  cof4_q [NUM_ENTRIES];
  logic signed [CFW-1:0]  cof5_q [NUM_ENTRIES];
  logic signed [PLW-1:0]  pl_q [NUM_DET_TERMS];
  logic signed [PLW-1:0]  ph_q [NUM_DET_TERMS];
  logic signed [DETW-1:0] t_q  [NUM_DET_TERMS];
  logic signed [DETW-1:0] det5_q;

  // whole pipeline moves unless the last item cannot leave
  assign adv     = !v5_q || ready_i;
  assign full_o  = !adv;
  assign valid_o = v5_q;
  assign cof_o   = cof5_q;
  assign det_o   = det5_q;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // two by two products
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        pa_q[i] <= PW'(m_i[COF_A[i]]) * PW'(m_i[COF_B[i]]);
        pb_q[i] <= PW'(m_i[COF_C[i]]) * PW'(m_i[COF_D[i]]);
      end
      for (int j = 0; j < NUM_DET_TERMS; j++) begin
        mk1_q[j] <= m_i[DET_COL[j]];
        mk2_q[j] <= mk1_q[j];
      end
      // cofactors
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        cof2_q[i] <= CFW'(pa_q[i]) - CFW'(pb_q[i]);
        cof3_q[i] <= cof2_q[i];
        cof4_q[i] <= cof3_q[i];
        cof5_q[i] <= cof4_q[i];
      end
      // determinant terms, cofactor split into low and high halves
      for (int j = 0; j < NUM_DET_TERMS; j++) begin
        pl_q[j] <= PLW'(mk2_q[j]) * PLW'($signed({1'b0, cof2_q[j][W-1:0]}));
        ph_q[j] <= PLW'(mk2_q[j]) * PLW'($signed(cof2_q[j][CFW-1:W]));
        t_q[j]  <= (DETW'(ph_q[j]) <<< W) + DETW'(pl_q[j]);
      end
      det5_q <= t_q[0] + t_q[1] + t_q[2];
    end
  end

endmodule

/* rtl/mi3_back.sv */
// ----------------------------------------------------------------------------
// mi3_back
// Divides the nine cofactors by the determinant with a pipelined restoring
// divider, one quotient bit per stage, and formats the results.
// ----------------------------------------------------------------------------
module mi3_back #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [2*W:0]   cof_i [mi3_pkg::NUM_ENTRIES],
  input  logic signed [3*W+1:0] det_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [W-1:0]        inv_o [mi3_pkg::NUM_ENTRIES],
  output logic [mi3_pkg::DET_WIDTH-1:0] det_o,
  output logic                sing_o
);

  import mi3_pkg::*;

  localparam int unsigned CFW  = 2 * W + 1;
  localparam int unsigned DETW = 3 * W + 2;
  localparam int unsigned MW   = 2 * W;
  localparam int unsigned NW   = 2 * W + 2 * F;
  localparam int unsigned DW   = 3 * W;
  localparam int unsigned CW   = (NW > DW + W) ? NW : DW + W;
  localparam int unsigned TQW  = DW + DET_FRAC;

  localparam logic [W-1:0] EMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] EMIN = {1'b1, {(W - 1){1'b0}}};
  localparam logic [DET_WIDTH-1:0] DMAX = {1'b0, {(DET_WIDTH - 1){1'b1}}};
  localparam logic [DET_WIDTH-1:0] DMIN = {1'b1, {(DET_WIDTH - 1){1'b0}}};

  logic adv;

  // magnitude stage
  logic              v0_q;
  logic [NW-1:0]     num0_q [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] neg0_q;
  logic [DW-1:0]     den0_q;
  logic              dneg0_q;

  // divider stages, index 0 holds the set-up stage
  logic                   v_q    [W+1];
  logic [CW-1:0]          rem_q  [W+1][NUM_ENTRIES];
  logic [W-1:0]           quo_q  [W+1][NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] neg_q  [W+1];
  logic [NUM_ENTRIES-1:0] ovf_q  [W+1];
  logic [DW-1:0]          den_q  [W+1];
  logic                   zero_q [W+1];
  logic [DET_WIDTH-1:0]   det_q  [W+1];

  // result stage
  logic                 vf_q;
  logic [W-1:0]         invf_q [NUM_ENTRIES];
  logic [DET_WIDTH-1:0] detf_q;
  logic                 singf_q;

  // set-up stage signals
  logic [TQW-1:0]       tq;
  logic                 tq_big;
  logic [DET_WIDTH-1:0] det_fmt;

  assign adv     = !vf_q || ready_i;
  assign ready_o = adv;
  assign valid_o = vf_q;
  assign inv_o   = invf_q;
  assign det_o   = detf_q;
  assign sing_o  = singf_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vf_q <= 1'b0;
      for (int s = 0; s <= W; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (adv) begin
      v0_q   <= valid_i;
      v_q[0] <= v0_q;
      for (int s = 0; s < W; s++) begin
        v_q[s+1] <= v_q[s];
      end
      vf_q <= v_q[W];
    end
  end

  // absolute values and scaled numerators
  always_ff @(posedge clk_i) begin
    logic [CFW-1:0]  cmag;
    logic [DETW-1:0] dmag;
    if (adv) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        cmag      = cof_i[i][CFW-1] ? (~cof_i[i] + 1'b1) : cof_i[i];
        num0_q[i] <= {cmag[MW-1:0], {(2 * F){1'b0}}};
        neg0_q[i] <= cof_i[i][CFW-1] ^ det_i[DETW-1];
      end
      dmag    = det_i[DETW-1] ? (~det_i + 1'b1) : det_i;
      den0_q  <= dmag[DW-1:0];
      dneg0_q <= det_i[DETW-1];
    end
  end

  // determinant brought to the output format, truncated and saturated
  always_comb begin
    tq     = {den0_q, {DET_FRAC{1'b0}}} >> (3 * F);
    tq_big = |tq[TQW-1:DET_WIDTH];
    if (!dneg0_q) begin
      det_fmt = (tq_big || tq[DET_WIDTH-1]) ? DMAX : tq[DET_WIDTH-1:0];
    end else if (tq_big || (tq[DET_WIDTH-1] && |tq[DET_WIDTH-2:0])) begin
      det_fmt = DMIN;
    end else begin
      det_fmt = ~tq[DET_WIDTH-1:0] + 1'b1;
    end
  end

  // set-up: quotient overflow check and singular detect
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        rem_q[0][i] <= CW'(num0_q[i]);
        quo_q[0][i] <= '0;
        ovf_q[0][i] <= CW'(num0_q[i]) >= (CW'(den0_q) << W);
      end
      neg_q[0]  <= neg0_q;
      den_q[0]  <= den0_q;
      zero_q[0] <= (den0_q == '0);
      det_q[0]  <= det_fmt;
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < W; s++) begin : g_div
    localparam int unsigned K = W - 1 - s;
    logic [CW:0] diff [NUM_ENTRIES];

    always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        diff[i] = {1'b0, rem_q[s][i]} - {1'b0, CW'(den_q[s]) << K};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          rem_q[s+1][i] <= diff[i][CW] ? rem_q[s][i] : diff[i][CW-1:0];
          quo_q[s+1][i] <= quo_q[s][i] | (W'(!diff[i][CW]) << K);
        end
        neg_q[s+1]  <= neg_q[s];
        ovf_q[s+1]  <= ovf_q[s];
        den_q[s+1]  <= den_q[s];
        zero_q[s+1] <= zero_q[s];
        det_q[s+1]  <= det_q[s];
      end
    end
  end

  // sign, saturation and singular handling
  always_ff @(posedge clk_i) begin
    logic [W-1:0] q;
    if (adv) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        q = quo_q[W][i];
        if (zero_q[W]) begin
          invf_q[i] <= '0;
        end else if (ovf_q[W][i]) begin
          invf_q[i] <= neg_q[W][i] ? EMIN : EMAX;
        end else if (!neg_q[W][i]) begin
          invf_q[i] <= q[W-1] ? EMAX : q;
        end else if (q[W-1] && |q[W-2:0]) begin
          invf_q[i] <= EMIN;
        end else begin
          invf_q[i] <= ~q + 1'b1;
        end
      end
      detf_q  <= zero_q[W] ? '0 : det_q[W];
      singf_q <= zero_q[W];
    end
  end

endmodule

/* test/matrix_inverse_3x3_checker.sv */
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_checker
// Watches both queue ports of the 3x3 matrix inverse, predicts determinant,
// inverse and singular flag for each accepted item and compares every
// popped result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             full_i,
  input  logic [8:0][31:0] mat_i,
  input  logic             pop_i,
  input  logic             empty_i,
  input  logic [8:0][31:0] inv_i,
  input  logic [63:0]      det_i,
  input  logic             singular_i,
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [8:0][31:0] inv;
    logic [63:0]      det;
    logic             singular;
  } inverse_t;

  inverse_t inverse_q[$];

  // quotient of cofactor over determinant, truncated toward zero, saturated
  function automatic logic [31:0] inv_entry(logic signed [127:0] cof,
                                            logic signed [127:0] det);
    logic [191:0] num;
    logic [191:0] den;
    logic [191:0] q;
    logic         neg;
    num = {64'd0, (cof < 0) ? -cof : cof} << 32;
    den = {64'd0, (det < 0) ? -det : det};
    q   = num / den;
    neg = (cof < 0) != (det < 0);
    if (!neg) return (q > 192'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
    if (q > 192'h8000_0000) q = 192'h8000_0000;
    return -q[31:0];
  endfunction

  // exact cofactor expansion along the first row
  function automatic inverse_t predict_inverse(logic [8:0][31:0] a);
    logic signed [127:0] m [9];
    logic signed [127:0] c [9];
    logic signed [127:0] det;
    logic [127:0]        mag;
    inverse_t            r;
    for (int i = 0; i < 9; i++) m[i] = {{96{a[i][31]}}, a[i]};
    c[0] = m[4] * m[8] - m[5] * m[7];
    c[3] = m[6] * m[5] - m[3] * m[8];
    c[6] = m[3] * m[7] - m[6] * m[4];
    c[1] = m[7] * m[2] - m[1] * m[8];
    c[4] = m[0] * m[8] - m[6] * m[2];
    c[7] = m[1] * m[6] - m[0] * m[7];
    c[2] = m[1] * m[5] - m[2] * m[4];
    c[5] = m[2] * m[3] - m[0] * m[5];
    c[8] = m[0] * m[4] - m[1] * m[3];
    det = m[0] * c[0] + m[3] * c[1] + m[6] * c[2];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int i = 0; i < 9; i++) r.inv[i] = inv_entry(c[i], det);
    // Q48 exact value down to Q32.32, truncated toward zero
    mag = ((det < 0) ? -det : det) >> 16;
    if (det >= 0) r.det = (mag > 128'h7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff : mag[63:0];
    else if (mag > 128'h8000_0000_0000_0000) r.det = 64'h8000_0000_0000_0000;
    else r.det = -mag[63:0];
    return r;
  endfunction

  assign pending_o = inverse_q.size();

  // predict on accepted items, compare on popped results
  always @(posedge clk_i or negedge rst_ni) begin
    inverse_t want;
    if (!rst_ni) begin
      errors_o = 0;
      inverse_q.delete();
    end else begin
      if (push_i && !full_i) inverse_q.push_back(predict_inverse(mat_i));
      if (pop_i && !empty_i) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: result with no item pending", $time);
          errors_o++;
        end else begin
          want = inverse_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (inv_i[i] !== want.inv[i]) begin
              $display("%0t: inverse entry %0d expected %h actual %h",
                       $time, i, want.inv[i], inv_i[i]);
              errors_o++;
            end
          if (det_i !== want.det) begin
            $display("%0t: determinant expected %h actual %h", $time, want.det, det_i);
            errors_o++;
          end
          if (singular_i !== want.singular) begin
            $display("%0t: singular expected %b actual %b",
                     $time, want.singular, singular_i);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

/* test/matrix_inverse_3x3_tb.sv */
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_tb
// Drives directed and random 3x3 matrices into the inverse block under
// varying push and pop pressure, including a long result-side stall, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             pop = 1'b0;
  logic             full, empty;
  logic [8:0][31:0] mat = '0;
  logic [8:0][31:0] inv;
  logic [63:0]      det;
  logic             singular;
  int               errors, pending;
  int               push_idle_pct = 28;
  int               pop_idle_pct = 61;
  int               hold_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  matrix_inverse_3x3 i_dut (
    .clk_i, .rst_ni, .push, .full,
    .a_r1c1_i(mat[0]), .a_r2c1_i(mat[1]), .a_r3c1_i(mat[2]),
    .a_r1c2_i(mat[3]), .a_r2c2_i(mat[4]), .a_r3c2_i(mat[5]),
    .a_r1c3_i(mat[6]), .a_r2c3_i(mat[7]), .a_r3c3_i(mat[8]),
    .pop, .empty,
    .inv_r1c1_o(inv[0]), .inv_r2c1_o(inv[1]), .inv_r3c1_o(inv[2]),
    .inv_r1c2_o(inv[3]), .inv_r2c2_o(inv[4]), .inv_r3c2_o(inv[5]),
    .inv_r1c3_o(inv[6]), .inv_r2c3_o(inv[7]), .inv_r3c3_o(inv[8]),
    .determinant_o(det), .singular_o(singular)
  );

  matrix_inverse_3x3_checker i_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .mat_i(mat),
    .pop_i(pop), .empty_i(empty), .inv_i(inv), .det_i(det),
    .singular_i(singular), .errors_o(errors), .pending_o(pending)
  );

  // result side: random pop, or a counted hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= $urandom_range(99) >= pop_idle_pct;
    end
  end

  // offer one matrix, idling first at random, and wait until taken
  task automatic send_matrix(logic [8:0][31:0] a);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    mat <= a;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  function automatic logic [31:0] small_q();
    return 32'($signed($urandom_range(8 * ONE)) - $signed(4 * ONE));
  endfunction

  // mostly well-conditioned, some singular, some full range, some extremes
  function automatic logic [8:0][31:0] random_matrix();
    logic [8:0][31:0] a;
    int               kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) a[i] = small_q();
    case (kind)
      0, 1: for (int i = 0; i < 9; i++) a[i] = $urandom();
      2: begin
        // two equal columns
        for (int i = 0; i < 3; i++) a[3 + i] = a[i];
      end
      3: begin
        // zero row
        a[$urandom_range(2)] = '0;
        a[3] = '0;
        a[6] = '0;
        a[0] = '0;
      end
      4: for (int i = 0; i < 9; i++) a[i] = $urandom_range(1) ? MAXV : MINV;
      5: for (int i = 0; i < 9; i++) a[i] = 32'($signed($urandom_range(6)) - 3);
      default: begin
        a[0] = a[0] + 8 * ONE;
        a[4] = a[4] + 8 * ONE;
        a[8] = a[8] + 8 * ONE;
      end
    endcase
    return a;
  endfunction

  task automatic send_phase(int n);
    for (int k = 0; k < n; k++) send_matrix(random_matrix());
  endtask

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, zero, extremes, tiny determinant, overflow
    send_matrix({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
    send_matrix('0);
    send_matrix({9{MAXV}});
    send_matrix({9{MINV}});
    send_matrix({MAXV, 32'd0, 32'd0, 32'd0, MAXV, 32'd0, 32'd0, 32'd0, MAXV});
    send_matrix({MINV, 32'd0, 32'd0, 32'd0, MINV, 32'd0, 32'd0, 32'd0, MINV});
    send_matrix({MINV, 32'd0, 32'd0, 32'd0, MAXV, 32'd0, 32'd0, 32'd0, MINV});
    send_matrix({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
    send_matrix({32'd2, 32'd0, 32'd0, 32'd0, -32'd1, 32'd0, 32'd0, 32'd0, 32'd3});
    send_matrix({32'd256, 32'd0, 32'd0, 32'd0, 32'd256, 32'd0, 32'd0, 32'd0, 32'd256});
    send_matrix({MAXV, MINV, 32'd0, 32'd0, MAXV, MINV, MINV, 32'd0, MAXV});
    send_matrix({32'hffff_ffff, 32'd0, 32'd0, 32'd0, 32'hffff_ffff, 32'd0,
                 32'd0, 32'd0, 32'hffff_ffff});
    send_matrix({2 * ONE, ONE, ONE, ONE, 2 * ONE, ONE, ONE, ONE, 2 * ONE});
    send_matrix({ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                 7 * ONE, 8 * ONE, 9 * ONE});
    send_matrix({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, -ONE});
    for (int i = 0; i < 4; i++) send_matrix({$urandom(), $urandom(), $urandom(),
      $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});

    // random phases with sender and receiver idling swapped, then no idling with a result-side hold-off
    send_phase(430);
    push_idle_pct = 61;
    pop_idle_pct = 28;
    send_phase(430);
    push_idle_pct = 0;
    pop_idle_pct = 0;
    hold_cycles <= 300;
    send_phase(430);
    push <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
